>>> rtl/rita_pkg.sv
// shared constants and the digit-to-ascii map for the radix integer-to-ascii core
`timescale 1ns / 1ps
`default_nettype none

package rita_pkg;

   // default width of the value field
   localparam int VALUE_BITS_DEF = 31;

   // radix field and accepted radix range
   localparam int RADIX_BITS = 6;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(36);

   // ascii character field
   localparam int CHAR_BITS = 7;
   localparam logic [CHAR_BITS-1:0] CHAR_NONE  = CHAR_BITS'(0);
   localparam logic [CHAR_BITS-1:0] ASCII_ZERO = CHAR_BITS'(48);
   localparam logic [CHAR_BITS-1:0] ASCII_LETTER_BASE = CHAR_BITS'(55);
   localparam logic [RADIX_BITS-1:0] DECIMAL_DIGITS = RADIX_BITS'(10);

   // remainder 0..35 to '0'-'9', 'A'-'Z'
   function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [RADIX_BITS-1:0] rem);
      logic [CHAR_BITS-1:0] base;
      base = (rem < DECIMAL_DIGITS) ? ASCII_ZERO : ASCII_LETTER_BASE;
      return base + CHAR_BITS'(rem);
   endfunction

endpackage

`default_nettype wire

>>> rtl/rita_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module rita_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/rita_div.sv
// bit-serial restoring divider: value by a 6-bit radix, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module rita_div #(
   parameter int VALUE_BITS = rita_pkg::VALUE_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [VALUE_BITS-1:0]           dividend,
   input  wire logic [rita_pkg::RADIX_BITS-1:0] divisor,
   output logic                                 done,
   output logic      [VALUE_BITS-1:0]           quotient,
   output logic      [rita_pkg::RADIX_BITS-1:0] remainder
);
   import rita_pkg::*;

   localparam int STEP_W = $clog2(VALUE_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [RADIX_BITS-1:0] rem_ff, rem_in;
   logic [RADIX_BITS-1:0] div_ff, div_in;

   logic [RADIX_BITS:0]   trial;
   logic [RADIX_BITS:0]   diff;
   logic                  fits;

   // one shift-compare-subtract step
   always_comb begin
      trial = {rem_ff, quo_ff[VALUE_BITS-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = (trial >= {1'b0, div_ff});
   end

   // next state of the divider
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(VALUE_BITS - 1);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_BITS-2:0], fits};
         rem_in = fits ? diff[RADIX_BITS-1:0] : trial[RADIX_BITS-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

>>> rtl/radix_integer_to_ascii_core.sv
// radix integer-to-ascii core: top level with sequencer, digit stack and result register
//
// usage
//  - req channel: one beat carries req_value and req_radix; req_stall is high while
//    a conversion is in progress, so a new beat is taken only once the previous
//    run has been fully delivered
//  - rsp channel: one beat per ascii digit, most significant first, rsp_last on the
//    final digit; a radix outside 2..36 gives a single beat with rsp_error and
//    rsp_last set and rsp_digit_char zero; the value zero gives the single digit '0'
//  - each digit comes from a full division in the bit-serial divider, then each digit
//    is popped from the digit stack through the fetch (read), load and send states
//  - a new beat of input waits until the previous run of digits is delivered; the single
//    shared divider does every division of a run, one after the other
//  - a radix error skips the divider and goes straight to the send state
//  - reset: synchronous, active high; returns to idle and drops rsp_valid
//  - rsp_stall holds the current result beat in the output register; the sequencer
//    waits and no digit is lost
`timescale 1ns / 1ps
`default_nettype none

module radix_integer_to_ascii_core #(
   parameter int VALUE_BITS = rita_pkg::VALUE_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [VALUE_BITS-1:0]           req_value,
   input  wire logic [rita_pkg::RADIX_BITS-1:0] req_radix,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [rita_pkg::CHAR_BITS-1:0]  rsp_digit_char,
   output logic                                 rsp_error,
   output logic                                 rsp_last
);
   import rita_pkg::*;

   localparam int PTR_W = $clog2(VALUE_BITS);
   localparam int CNT_W = $clog2(VALUE_BITS + 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV   = 5'b00010,
      ST_FETCH = 5'b00100,
      ST_LOAD  = 5'b01000,
      ST_SEND  = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [CHAR_BITS-1:0]   digit_ff, digit_in;
   logic                   error_ff, error_in;
   logic                   last_ff, last_in;

   // radix held for repeated divisions
   logic [RADIX_BITS-1:0]  req_radix_hold_ff, req_radix_hold_in;

   logic                   req_beat;
   logic                   rsp_beat;
   logic                   radix_ok;
   logic                   div_start;
   logic [VALUE_BITS-1:0]  div_dividend;
   logic [RADIX_BITS-1:0]  div_divisor;
   logic                   div_done;
   logic [VALUE_BITS-1:0]  div_quotient;
   logic [RADIX_BITS-1:0]  div_remainder;
   logic                   stk_wr_en;
   logic [PTR_W-1:0]       stk_wr_addr;
   logic [PTR_W-1:0]       stk_rd_addr;
   logic [CHAR_BITS-1:0]   stk_wr_data;
   logic [CHAR_BITS-1:0]   stk_rd_data;
   logic [CNT_W-1:0]       cnt_top;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;
   assign radix_ok = (req_radix >= RADIX_MIN) && (req_radix <= RADIX_MAX);

   // shared divider
   rita_div #(
      .VALUE_BITS(VALUE_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // digit stack, least significant digit pushed first
   rita_ram #(
      .WIDTH(CHAR_BITS),
      .DEPTH(VALUE_BITS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   assign cnt_top     = cnt_ff - CNT_W'(1);
   assign stk_wr_addr = cnt_ff[PTR_W-1:0];
   assign stk_rd_addr = cnt_top[PTR_W-1:0];
   assign stk_wr_data = digit_to_ascii(div_remainder);

   // sequencer
   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      digit_in          = digit_ff;
      error_in          = error_ff;
      last_in           = last_ff;
      req_radix_hold_in = req_radix_hold_ff;
      div_start         = 1'b0;
      div_dividend      = div_quotient;
      div_divisor       = req_radix_hold_ff;
      stk_wr_en         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_beat) begin
               req_radix_hold_in = req_radix;
               if (radix_ok) begin
                  // first division takes the radix straight from the beat
                  div_start    = 1'b1;
                  div_dividend = req_value;
                  div_divisor  = req_radix;
                  state_in     = ST_DIV;
               end else begin
                  digit_in = CHAR_NONE;
                  error_in = 1'b1;
                  last_in  = 1'b1;
                  state_in = ST_SEND;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               stk_wr_en = 1'b1;
               cnt_in    = cnt_ff + CNT_W'(1);
               if (div_quotient != '0) begin
                  div_start = 1'b1;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            digit_in = stk_rd_data;
            error_in = 1'b0;
            last_in  = (cnt_ff == CNT_W'(1));
            cnt_in   = cnt_top;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_beat) begin
               state_in = last_ff ? ST_IDLE : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // result beat and radix registers
   always_ff @(posedge clock) begin
      digit_ff          <= digit_in;
      error_ff          <= error_in;
      last_ff           <= last_in;
      req_radix_hold_ff <= req_radix_hold_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_SEND);
   assign rsp_digit_char = digit_ff;
   assign rsp_error      = error_ff;
   assign rsp_last       = last_ff;

   // an error beat is always the only beat of its run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_last && (cnt_ff == '0)))
      else $error("error beat not alone in its run");

   // the digit stack never overflows
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(VALUE_BITS))
      else $error("digit stack overflow");

   // divider completes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider done outside of a division");

   // the last digit pops the stack empty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last && !rsp_error) |-> (cnt_ff == '0))
      else $error("last digit with digits left on the stack");

endmodule

`default_nettype wire

>>> dv/radix_integer_to_ascii_core_tb.sv
// self-checking testbench for the radix integer-to-ascii core
`timescale 1ns / 1ps

module radix_integer_to_ascii_core_tb;

   import rita_pkg::*;

   localparam int VALUE_BITS   = VALUE_BITS_DEF;
   localparam int TEXT_BYTES   = 32;
   localparam int TEXT_W       = TEXT_BYTES * 8;
   localparam int RESET_CYCLES = 4;
   localparam int RANDOM_ITEMS = 238;
   localparam int QUIET_LIMIT  = 20000;
   localparam int HOLD_CYCLES  = 3000;
   localparam int DRAIN_CYCLES = 100;
   localparam int REPORT_MAX   = 10;
   localparam int IDLE_PCT     = 9;
   // sender and receiver windows with no idling at all
   localparam int SEND_CALM_FROM = 120;
   localparam int SEND_CALM_TO   = 180;
   localparam int RECV_CALM_FROM = 700;
   localparam int RECV_CALM_TO   = 1200;
   localparam int HOLD_AFTER     = 150;

   localparam logic [VALUE_BITS-1:0] VALUE_MAX   = {VALUE_BITS{1'b1}};
   localparam logic [CHAR_BITS-1:0]  CH_ZERO     = CHAR_BITS'(8'h30);
   localparam logic [CHAR_BITS-1:0]  CH_LETTER_A = CHAR_BITS'(8'h41);
   localparam logic [RADIX_BITS-1:0] TEN         = RADIX_BITS'(10);

   // how a stimulus row gets its expected digits
   typedef enum logic [1:0] {
      CHECK_MODEL,
      CHECK_TEXT,
      CHECK_ERROR
   } check_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [RADIX_BITS-1:0] radix;
      check_type             check;
      logic [TEXT_W-1:0]     text;
   } dir_row_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] ch;
      logic                 err;
      logic                 fin;
   } digit_beat_type;

   // directed rows: extremes, single digits, carries and bad radices
   localparam int DIR_ROWS = 23;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{'0,          6'd10, CHECK_TEXT,  "0"},
      '{'0,          6'd2,  CHECK_TEXT,  "0"},
      '{'0,          6'd36, CHECK_TEXT,  "0"},
      '{VALUE_MAX,   6'd2,  CHECK_TEXT,  "1111111111111111111111111111111"},
      '{VALUE_MAX,   6'd10, CHECK_TEXT,  "2147483647"},
      '{VALUE_MAX,   6'd16, CHECK_TEXT,  "7FFFFFFF"},
      '{VALUE_MAX,   6'd36, CHECK_TEXT,  "ZIK0ZJ"},
      '{VALUE_MAX,   6'd8,  CHECK_TEXT,  "17777777777"},
      '{31'd1,       6'd2,  CHECK_TEXT,  "1"},
      '{31'd35,      6'd36, CHECK_TEXT,  "Z"},
      '{31'd36,      6'd36, CHECK_TEXT,  "10"},
      '{31'd10,      6'd11, CHECK_TEXT,  "A"},
      '{31'd255,     6'd16, CHECK_TEXT,  "FF"},
      '{31'd1000000, 6'd10, CHECK_TEXT,  "1000000"},
      '{31'd5,       6'd0,  CHECK_ERROR, '0},
      '{31'd5,       6'd1,  CHECK_ERROR, '0},
      '{VALUE_MAX,   6'd37, CHECK_ERROR, '0},
      '{'0,          6'd63, CHECK_ERROR, '0},
      '{31'd12345,   6'd32, CHECK_MODEL, '0},
      '{31'd1431655765, 6'd3, CHECK_MODEL, '0},
      '{31'd715827882,  6'd7, CHECK_MODEL, '0},
      '{31'd1073741824, 6'd2, CHECK_MODEL, '0},
      '{31'd123456789, 6'd35, CHECK_MODEL, '0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic [RADIX_BITS-1:0] req_radix = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CHAR_BITS-1:0]  rsp_digit_char;
   logic                  rsp_error;
   logic                  rsp_last;

   // stimulus, one entry per input beat
   logic [VALUE_BITS-1:0] stim_value [$];
   logic [RADIX_BITS-1:0] stim_radix [$];
   check_type             stim_check [$];
   logic [TEXT_W-1:0]     stim_text  [$];

   digit_beat_type digits_due [$];

   int send_idx      = 0;
   int mismatches    = 0;
   int beats_checked = 0;
   int bad_radix_cnt = 0;
   int longest_run   = 0;
   int quiet_cycles  = 0;
   int recv_beats    = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;

   radix_integer_to_ascii_core #(
      .VALUE_BITS(VALUE_BITS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_radix      (req_radix),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_error      (rsp_error),
      .rsp_last       (rsp_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void push_digit(input logic [CHAR_BITS-1:0] ch, input logic err,
                                      input logic fin);
      digit_beat_type b;
      b.ch  = ch;
      b.err = err;
      b.fin = fin;
      digits_due.push_back(b);
   endfunction

   function automatic void push_bad_radix();
      push_digit(CHAR_NONE, 1'b1, 1'b1);
      bad_radix_cnt++;
   endfunction

   // repeated division, least significant digit first, then replayed msd first
   function automatic void push_conversion(input logic [VALUE_BITS-1:0] value,
                                           input logic [RADIX_BITS-1:0] radix);
      logic [CHAR_BITS-1:0]  stack [VALUE_BITS];
      logic [VALUE_BITS-1:0] rest;
      logic [RADIX_BITS-1:0] rem;
      int                    depth;
      if (radix < RADIX_MIN || radix > RADIX_MAX) begin
         push_bad_radix();
         return;
      end
      rest  = value;
      depth = 0;
      do begin
         rem = RADIX_BITS'(rest % VALUE_BITS'(radix));
         stack[depth] = (rem < TEN) ? CH_ZERO + CHAR_BITS'(rem)
                                    : CH_LETTER_A + CHAR_BITS'(rem - TEN);
         depth++;
         rest = rest / VALUE_BITS'(radix);
      end while (rest != 0);
      for (int k = depth - 1; k >= 0; k--) begin
         push_digit(stack[k], 1'b0, k == 0);
      end
      if (depth > longest_run) longest_run = depth;
   endfunction

   // typed digit string, right-justified in the text field
   function automatic void push_text(input logic [TEXT_W-1:0] text);
      logic [7:0] ch;
      for (int i = TEXT_BYTES - 1; i >= 0; i--) begin
         ch = text[i*8 +: 8];
         if (ch != 8'h00) push_digit(CHAR_BITS'(ch), 1'b0, i == 0);
      end
   endfunction

   function automatic void expect_item(input int idx);
      unique case (stim_check[idx])
         CHECK_TEXT:  push_text(stim_text[idx]);
         CHECK_ERROR: push_bad_radix();
         default:     push_conversion(stim_value[idx], stim_radix[idx]);
      endcase
   endfunction

   function automatic void add_item(input logic [VALUE_BITS-1:0] value,
                                    input logic [RADIX_BITS-1:0] radix,
                                    input check_type check, input logic [TEXT_W-1:0] text);
      stim_value.push_back(value);
      stim_radix.push_back(radix);
      stim_check.push_back(check);
      stim_text.push_back(text);
   endfunction

   // random items: mostly good radices, some bad ones, values of random length
   function automatic void add_random_items();
      logic [VALUE_BITS-1:0] value;
      logic [RADIX_BITS-1:0] radix;
      int                    roll;
      int                    nbits;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            radix = ($urandom_range(0, 3) == 0) ? RADIX_BITS'($urandom_range(0, 1))
                                                : RADIX_BITS'($urandom_range(37, 63));
         end else if (roll < 30) begin
            radix = RADIX_MIN;
         end else begin
            radix = RADIX_BITS'($urandom_range(RADIX_MIN, RADIX_MAX));
         end
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            value = '0;
         end else if (roll < 16) begin
            value = VALUE_MAX;
         end else begin
            nbits = $urandom_range(1, VALUE_BITS);
            value = VALUE_BITS'($urandom) & VALUE_BITS'((64'd1 << nbits) - 1);
         end
         add_item(value, radix, CHECK_MODEL, '0);
      end
   endfunction

   // sender: takes an accepted beat, then offers the next item or idles
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expect_item(send_idx);
            send_idx = send_idx + 1;
         end
         if (!req_valid || !req_stall) begin
            if (send_idx < stim_value.size() &&
                (($urandom_range(0, 99) >= IDLE_PCT) ||
                 (send_idx >= SEND_CALM_FROM && send_idx < SEND_CALM_TO))) begin
               req_valid <= 1'b1;
               req_value <= stim_value[send_idx];
               req_radix <= stim_radix[send_idx];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stall, a calm window and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) recv_beats <= recv_beats + 1;
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (!hold_done && recv_beats >= HOLD_AFTER) begin
            rsp_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end else if (recv_beats >= RECV_CALM_FROM && recv_beats < RECV_CALM_TO) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   // digit checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digits_due.size() == 0) begin
            if (mismatches < REPORT_MAX)
               $display("unexpected digit beat: char %0d err %0b last %0b",
                        rsp_digit_char, rsp_error, rsp_last);
            mismatches++;
         end else begin
            if (rsp_digit_char !== digits_due[0].ch || rsp_error !== digits_due[0].err ||
                rsp_last !== digits_due[0].fin) begin
               if (mismatches < REPORT_MAX)
                  $display({"digit beat %0d: expected char %0d err %0b last %0b,",
                            " got char %0d err %0b last %0b"},
                           beats_checked, digits_due[0].ch, digits_due[0].err,
                           digits_due[0].fin, rsp_digit_char, rsp_error, rsp_last);
               mismatches++;
            end
            void'(digits_due.pop_front());
         end
         beats_checked++;
      end
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      for (int i = 0; i < DIR_ROWS; i++) begin
         add_item(DIRECTED[i].value, DIRECTED[i].radix, DIRECTED[i].check, DIRECTED[i].text);
      end
      add_random_items();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (!(send_idx == stim_value.size() && digits_due.size() == 0) &&
             quiet_cycles < QUIET_LIMIT)
         @(negedge clock);

      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("stuck for %0d cycles: %0d items not sent, %0d digits outstanding",
                  QUIET_LIMIT, stim_value.size() - send_idx, digits_due.size());
         $display("FAILURE");
      end else begin
         repeat (DRAIN_CYCLES) @(negedge clock);
         $display("%0d conversions (%0d table rows, %0d bad radix), %0d digit beats",
                  send_idx, DIR_ROWS, bad_radix_cnt, beats_checked);
         $display("longest run %0d digits, one receiver hold-off of %0d cycles, %0d mismatches",
                  longest_run, HOLD_CYCLES, mismatches);
         if (mismatches == 0 && digits_due.size() == 0)
            $display("SUCCESS");
         else
            $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/rita_pkg.sv
rtl/rita_ram.sv
rtl/rita_div.sv
rtl/radix_integer_to_ascii_core.sv
dv/radix_integer_to_ascii_core_tb.sv
